@@ rtl/pbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Pinhole back projection package
// Shared widths, register indexes and the derived configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pbp_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // Configuration port.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 64;
  localparam logic [CFG_AW-1:0] CFG_M00_M01 = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_M02_T0  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_M10_M11 = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_M12_T1  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_M20_M21 = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_M22_T2  = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_DIST    = 3'd6;

  // Datapath widths.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned ADJ_W   = 65;
  localparam int unsigned WW      = 65;
  localparam int unsigned MAG_W   = 64;
  localparam int unsigned PROD_W  = 128;
  localparam int unsigned TERM_W  = 129;
  localparam int unsigned NUM_W   = 130;
  localparam int unsigned N2_W    = 130;
  localparam int unsigned DET_W   = 99;
  localparam int unsigned D2_W    = 99;
  localparam int unsigned QB      = 48;
  localparam int unsigned CMP_W   = D2_W + QB - 1;

  // Cycles for the derived configuration terms to settle after a write.
  localparam int unsigned SETTLE = 6;
  localparam int unsigned SET_W  = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0]  plane_dist;
    logic signed [COORD_W-1:0]  t0;
    logic signed [COORD_W-1:0]  t1;
    logic signed [WW-1:0]       w2;
    logic [2:0][2:0][MAG_W-1:0] adj_mag;
    logic [2:0][2:0]            adj_neg;
    logic [D2_W-1:0]            d2;
    logic                       det_neg;
    logic                       singular;
  } pbp_cfg_t;

endpackage

`default_nettype wire

@@ rtl/pbp_ifs.sv @@
// ----------------------------------------------------------------------------
// Pinhole back projection channels
// Valid/ready interfaces for configuration, image points and 3D results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbp_cfg_if import pbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

interface pbp_in_if import pbp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  modport source (output valid, x_coord, y_coord, input ready);
  modport sink (input valid, x_coord, y_coord, output ready);
endinterface

interface pbp_out_if import pbp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] world_x;
  logic signed [OUT_W-1:0] world_y;
  logic signed [OUT_W-1:0] world_z;
  logic                    singular;
  modport source (output valid, world_x, world_y, world_z, singular, input ready);
  modport sink (input valid, world_x, world_y, world_z, singular, output ready);
endinterface

`default_nettype wire

@@ rtl/pbp_cfg.sv @@
// ----------------------------------------------------------------------------
// Pinhole back projection configuration
// Matrix and distance registers, plus a pipelined adjugate and determinant.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_cfg import pbp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbp_cfg_if.sink   cfg_ch,
  output pbp_cfg_t  cfg_o,
  output logic      settled_o
);

  localparam logic [CFG_DW-1:0]  ONE_HI   = CFG_DW'(1) << (32 + FRAC_BITS);
  localparam logic [CFG_DW-1:0]  ONE_LO   = CFG_DW'(1) << FRAC_BITS;
  localparam logic [COORD_W-1:0] DIST_ONE = COORD_W'(1) << FRAC_BITS;

  logic [5:0][CFG_DW-1:0]    mat_q;
  logic [COORD_W-1:0]        dist_q;
  logic [SET_W-1:0]          set_q;
  logic signed [COORD_W-1:0] c_el [3][3];
  logic signed [COORD_W-1:0] t_el [3];

  logic signed [63:0]        pa_q [3][3];
  logic signed [63:0]        pb_q [3][3];
  logic signed [WW-1:0]      w2_q;
  logic signed [ADJ_W-1:0]   adj_q [3][3];
  logic [MAG_W-1:0]          adj_mag_q [3][3];
  logic                      adj_neg_q [3][3];
  logic signed [64:0]        dl_q [3];
  logic signed [64:0]        dh_q [3];
  logic signed [DET_W-1:0]   term_q [3];
  logic signed [DET_W-1:0]   det_q;
  logic [D2_W-1:0]           d2_q;
  logic                      det_neg_q;
  logic                      singular_q;
  logic                      wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid & cfg_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= ONE_HI;
      mat_q[1] <= '0;
      mat_q[2] <= ONE_LO;
      mat_q[3] <= '0;
      mat_q[4] <= '0;
      mat_q[5] <= ONE_HI;
      dist_q   <= DIST_ONE;
    end else if (wr) begin
      unique case (cfg_ch.addr) inside
        CFG_M00_M01, CFG_M02_T0, CFG_M10_M11, CFG_M12_T1, CFG_M20_M21, CFG_M22_T2: begin
          mat_q[cfg_ch.addr] <= cfg_ch.data;
        end
        CFG_DIST: begin
          dist_q <= cfg_ch.data[COORD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Items are held off until a write has passed through every derived stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q <= SET_W'(SETTLE);
    end else if (wr) begin
      set_q <= SET_W'(SETTLE);
    end else if (set_q != '0) begin
      set_q <= set_q - SET_W'(1);
    end
  end
  assign settled_o = (set_q == '0);

  for (genvar gr = 0; gr < 3; gr++) begin : g_el
    assign c_el[gr][0] = mat_q[2*gr][63:32];
    assign c_el[gr][1] = mat_q[2*gr][31:0];
    assign c_el[gr][2] = mat_q[2*gr+1][63:32];
    assign t_el[gr]    = mat_q[2*gr+1][31:0];
  end

  always_ff @(posedge clk_i) begin
    w2_q <= (WW'($signed(dist_q)) - WW'(t_el[2])) <<< FRAC_BITS;
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam int I1 = (gi + 1) % 3;
      localparam int I2 = (gi + 2) % 3;
      localparam int J1 = (gj + 1) % 3;
      localparam int J2 = (gj + 2) % 3;
      always_ff @(posedge clk_i) begin
        pa_q[gi][gj]      <= c_el[J1][I1] * c_el[J2][I2];
        pb_q[gi][gj]      <= c_el[J1][I2] * c_el[J2][I1];
        adj_q[gi][gj]     <= ADJ_W'(pa_q[gi][gj]) - ADJ_W'(pb_q[gi][gj]);
        adj_neg_q[gi][gj] <= adj_q[gi][gj][ADJ_W-1];
        adj_mag_q[gi][gj] <= adj_q[gi][gj][ADJ_W-1] ? MAG_W'(-adj_q[gi][gj])
                                                    : MAG_W'(adj_q[gi][gj]);
      end
    end
  end

  // Determinant by expansion along row 0, with each adjugate entry split in
  // two halves so that every multiplier stays near 32 by 32.
  for (genvar gk = 0; gk < 3; gk++) begin : g_det
    always_ff @(posedge clk_i) begin
      dl_q[gk]   <= c_el[0][gk] * $signed({1'b0, adj_q[gk][0][31:0]});
      dh_q[gk]   <= c_el[0][gk] * $signed(adj_q[gk][0][ADJ_W-1:32]);
      term_q[gk] <= (DET_W'(dh_q[gk]) <<< 32) + DET_W'(dl_q[gk]);
    end
  end

  always_ff @(posedge clk_i) begin
    det_q      <= term_q[0] + term_q[1] + term_q[2];
    det_neg_q  <= det_q[DET_W-1];
    singular_q <= (det_q == '0);
    d2_q       <= det_q[DET_W-1] ? D2_W'(-det_q) << 1 : D2_W'(det_q) << 1;
  end

  always_comb begin
    cfg_o.plane_dist = $signed(dist_q);
    cfg_o.t0         = t_el[0];
    cfg_o.t1         = t_el[1];
    cfg_o.w2         = w2_q;
    cfg_o.d2         = d2_q;
    cfg_o.det_neg    = det_neg_q;
    cfg_o.singular   = singular_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cfg_o.adj_mag[i][j] = adj_mag_q[i][j];
        cfg_o.adj_neg[i][j] = adj_neg_q[i][j];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/pbp_mac.sv @@
// ----------------------------------------------------------------------------
// Pinhole back projection multiply-accumulate
// Six stages from an image point to the rounded dividends of three lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_mac import pbp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pbp_cfg_t                  cfg_i,
  input  logic                      up_valid_i,
  output logic                      up_ready_o,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] y_i,
  output logic                      dn_valid_o,
  input  logic                      dn_ready_i,
  output logic [2:0][N2_W-1:0]      n2_o,
  output logic [2:0]                neg_o
);

  localparam int unsigned NS = 6;

  logic [NS-1:0]           v_q;
  logic [NS:0]             en;
  logic [NS-1:0]           v_in;

  logic signed [63:0]      px_q;
  logic signed [63:0]      py_q;
  logic signed [WW-1:0]    w [3];
  logic [MAG_W-1:0]        wmag_q [3];
  logic                    wneg_q [3];
  logic [63:0]             pp_q [3][3][4];
  logic                    sgn_q [3][3];
  logic [TERM_W-1:0]       term_q [3][3];
  logic signed [NUM_W-1:0] num_q [3];
  logic [N2_W-1:0]         n2_q [3];
  logic                    neg_q [3];

  // A stage takes new data when it is empty or its successor moves.
  assign en[NS] = dn_ready_i;
  for (genvar gk = 0; gk < NS; gk++) begin : g_en
    assign en[gk] = !v_q[gk] || en[gk+1];
  end
  assign v_in = {v_q[NS-2:0], up_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  assign up_ready_o = en[0];
  assign dn_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      px_q <= x_i * cfg_i.plane_dist;
      py_q <= y_i * cfg_i.plane_dist;
    end
  end

  assign w[0] = WW'(px_q) - (WW'($signed(cfg_i.t0)) <<< FRAC_BITS);
  assign w[1] = WW'(py_q) - (WW'($signed(cfg_i.t1)) <<< FRAC_BITS);
  assign w[2] = cfg_i.w2;

  for (genvar gj = 0; gj < 3; gj++) begin : g_w
    always_ff @(posedge clk_i) begin
      if (en[1]) begin
        wneg_q[gj] <= w[gj][WW-1];
        wmag_q[gj] <= w[gj][WW-1] ? MAG_W'(-w[gj]) : MAG_W'(w[gj]);
      end
    end
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_lane
    for (genvar gj = 0; gj < 3; gj++) begin : g_tap
      logic [PROD_W-1:0] prod;
      for (genvar gb = 0; gb < 4; gb++) begin : g_part
        localparam int unsigned HA = 32 * (gb / 2);
        localparam int unsigned HW = 32 * (gb % 2);
        always_ff @(posedge clk_i) begin
          if (en[2]) begin
            pp_q[gi][gj][gb] <= cfg_i.adj_mag[gi][gj][HA +: 32] * wmag_q[gj][HW +: 32];
          end
        end
      end
      always_ff @(posedge clk_i) begin
        if (en[2]) begin
          sgn_q[gi][gj] <= cfg_i.adj_neg[gi][gj] ^ wneg_q[gj];
        end
      end
      assign prod = PROD_W'(pp_q[gi][gj][0]) + (PROD_W'(pp_q[gi][gj][1]) << 32)
                  + (PROD_W'(pp_q[gi][gj][2]) << 32) + (PROD_W'(pp_q[gi][gj][3]) << 64);
      always_ff @(posedge clk_i) begin
        if (en[3]) begin
          term_q[gi][gj] <= sgn_q[gi][gj] ? -TERM_W'(prod) : TERM_W'(prod);
        end
      end
    end

    logic [NUM_W-1:0] nmag;
    always_ff @(posedge clk_i) begin
      if (en[4]) begin
        num_q[gi] <= NUM_W'($signed(term_q[gi][0])) + NUM_W'($signed(term_q[gi][1]))
                   + NUM_W'($signed(term_q[gi][2]));
      end
    end

    // Rounding half away from zero: floor((2|n| + |det|) / (2|det|)).
    assign nmag = num_q[gi][NUM_W-1] ? NUM_W'(-num_q[gi]) : NUM_W'(num_q[gi]);
    always_ff @(posedge clk_i) begin
      if (en[5]) begin
        n2_q[gi]  <= N2_W'({nmag, 1'b0}) + N2_W'(cfg_i.d2[D2_W-1:1]);
        neg_q[gi] <= num_q[gi][NUM_W-1] ^ cfg_i.det_neg;
      end
    end

    assign n2_o[gi]  = n2_q[gi];
    assign neg_o[gi] = neg_q[gi];
  end

endmodule

`default_nettype wire

@@ rtl/pbp_div.sv @@
// ----------------------------------------------------------------------------
// Pinhole back projection divider
// Pipelined restoring division, one quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_div import pbp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [D2_W-1:0]      d2_i,
  input  logic                 up_valid_i,
  output logic                 up_ready_o,
  input  logic [2:0][N2_W-1:0] n2_i,
  input  logic [2:0]           neg_i,
  output logic                 dn_valid_o,
  input  logic                 dn_ready_i,
  output logic [2:0][QB-1:0]   q_o,
  output logic [2:0]           neg_o
);

  logic [QB-1:0]   v_q;
  logic [QB:0]     en;
  logic [QB-1:0]   v_in;
  logic [N2_W-1:0] r_q [QB][3];
  logic [QB-1:0]   q_q [QB][3];
  logic            ng_q [QB][3];

  assign en[QB] = dn_ready_i;
  for (genvar gs = 0; gs < QB; gs++) begin : g_en
    assign en[gs] = !v_q[gs] || en[gs+1];
  end
  assign v_in = {v_q[QB-2:0], up_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < QB; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  assign up_ready_o = en[0];
  assign dn_valid_o = v_q[QB-1];

  // Stage s decides quotient bit QB-1-s. A set top bit means the magnitude
  // saturates, so the bits below it are never used.
  for (genvar gs = 0; gs < QB; gs++) begin : g_stage
    localparam int unsigned K = QB - 1 - gs;
    logic [CMP_W-1:0] dsh;
    assign dsh = CMP_W'(d2_i) << K;
    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      logic [N2_W-1:0]  r_in;
      logic [QB-1:0]    q_in;
      logic             ng_in;
      logic [CMP_W-1:0] rx;
      logic             ge;
      if (gs == 0) begin : g_first
        assign r_in  = n2_i[gl];
        assign q_in  = '0;
        assign ng_in = neg_i[gl];
      end else begin : g_next
        assign r_in  = r_q[gs-1][gl];
        assign q_in  = q_q[gs-1][gl];
        assign ng_in = ng_q[gs-1][gl];
      end
      assign rx = CMP_W'(r_in);
      assign ge = (rx >= dsh);
      always_ff @(posedge clk_i) begin
        if (en[gs]) begin
          r_q[gs][gl]  <= ge ? N2_W'(rx - dsh) : r_in;
          q_q[gs][gl]  <= {q_in[QB-2:0], ge};
          ng_q[gs][gl] <= ng_in;
        end
      end
    end
  end

  for (genvar gl = 0; gl < 3; gl++) begin : g_out
    assign q_o[gl]   = q_q[QB-1][gl];
    assign neg_o[gl] = ng_q[QB-1][gl];
  end

endmodule

`default_nettype wire

@@ rtl/pinhole_back_projection_unit.sv @@
// ----------------------------------------------------------------------------
// Pinhole back projection unit
// Maps an image point to a 3D point on a plane through a 3x4 camera matrix.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch  writes one register per request: index 0..5 are the matrix rows
//           packed as two Q16.16 halves, index 6 the plane distance. Other
//           indexes are ignored. Write only while no point is in flight.
//   in_ch   carries one image point (x, y) per request.
//   out_ch  returns world_x/y/z in Q32.16, rounded half away from zero and
//           saturated, with singular set and a zero point when det(C) = 0.
// Throughput is one point per cycle while out_ch does not stall. A result
// passes through six multiply/accumulate stages, 48 divider stages of
// one quotient bit each, and the output register.
// After reset and after every configuration write, in_ch.ready stays low
// while the adjugate and determinant pipeline settles. Reset loads
// the identity matrix and a distance of 1.0.
// When out_ch stalls, the output register holds and earlier stages keep
// taking requests until every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module pinhole_back_projection_unit import pbp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbp_cfg_if.sink    cfg_ch,
  pbp_in_if.sink     in_ch,
  pbp_out_if.source  out_ch
);

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  pbp_cfg_t             cfg;
  logic                 settled;
  logic                 mac_ready;
  logic                 mac_valid;
  logic                 div_ready;
  logic                 div_valid;
  logic [2:0][N2_W-1:0] n2;
  logic [2:0]           mac_neg;
  logic [2:0][QB-1:0]   quo;
  logic [2:0]           div_neg;
  logic                 en_out;
  logic                 ov_q;
  logic [OUT_W-1:0]     res [3];
  logic [OUT_W-1:0]     res_q [3];
  logic                 sing_q;

  pbp_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_ch    (cfg_ch),
    .cfg_o     (cfg),
    .settled_o (settled)
  );

  assign in_ch.ready = mac_ready & settled;

  pbp_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .up_valid_i (in_ch.valid & settled),
    .up_ready_o (mac_ready),
    .x_i        (in_ch.x_coord),
    .y_i        (in_ch.y_coord),
    .dn_valid_o (mac_valid),
    .dn_ready_i (div_ready),
    .n2_o       (n2),
    .neg_o      (mac_neg)
  );

  pbp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .d2_i       (cfg.d2),
    .up_valid_i (mac_valid),
    .up_ready_o (div_ready),
    .n2_i       (n2),
    .neg_i      (mac_neg),
    .dn_valid_o (div_valid),
    .dn_ready_i (en_out),
    .q_o        (quo),
    .neg_o      (div_neg)
  );

  for (genvar gl = 0; gl < 3; gl++) begin : g_sat
    logic [OUT_W-1:0] mag;
    logic             sat;
    assign sat = quo[gl][QB-1];
    assign mag = OUT_W'(quo[gl][QB-2:0]);
    always_comb begin
      if (cfg.singular) begin
        res[gl] = '0;
      end else if (div_neg[gl]) begin
        res[gl] = sat ? OUT_MIN : -mag;
      end else begin
        res[gl] = sat ? OUT_MAX : mag;
      end
    end
  end

  assign en_out = !ov_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_out) begin
      ov_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      res_q[0] <= res[0];
      res_q[1] <= res[1];
      res_q[2] <= res[2];
      sing_q   <= cfg.singular;
    end
  end

  assign out_ch.valid    = ov_q;
  assign out_ch.world_x  = $signed(res_q[0]);
  assign out_ch.world_y  = $signed(res_q[1]);
  assign out_ch.world_z  = $signed(res_q[2]);
  assign out_ch.singular = sing_q;

endmodule

`default_nettype wire

@@ rtl/pbp_chk.sv @@
// ----------------------------------------------------------------------------
// Pinhole back projection checker
// Port-level assertions, attached to the top level by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_chk import pbp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_valid_i,
  input logic             cfg_ready_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] world_x_i,
  input logic [OUT_W-1:0] world_y_i,
  input logic [OUT_W-1:0] world_z_i,
  input logic             singular_i
);

  // A singular matrix always yields the origin.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && singular_i |-> world_x_i == '0 && world_y_i == '0 && world_z_i == '0)
    else $error("singular result is not the zero point");

  // A stalled result holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(world_x_i)
      && $stable(world_y_i) && $stable(world_z_i) && $stable(singular_i))
    else $error("stalled result changed");

  // Points are held off while the derived matrix terms settle.
  a_cfg_holdoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("point accepted right after a configuration write");

endmodule

bind pinhole_back_projection_unit pbp_chk u_pbp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_ch.valid),
  .cfg_ready_i (cfg_ch.ready),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .world_x_i   (out_ch.world_x),
  .world_y_i   (out_ch.world_y),
  .world_z_i   (out_ch.world_z),
  .singular_i  (out_ch.singular)
);

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Pinhole back projection unit testbench
// Drives image points under several camera matrices and plane distances,
// predicts each 3D point with exact wide integer arithmetic and compares every
// returned result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import pbp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned FRAC = FRAC_BITS_DEF;
  localparam int HOLD_AT  = 500;
  localparam int HOLD_LEN = 400;

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0] umag_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct {
    logic signed [OUT_W-1:0] wx;
    logic signed [OUT_W-1:0] wy;
    logic signed [OUT_W-1:0] wz;
    logic                    sing;
  } world_t;

  logic clk_i;
  logic rst_ni;

  pbp_cfg_if cfg_ch ();
  pbp_in_if  in_ch ();
  pbp_out_if out_ch ();

  pinhole_back_projection_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Camera copy kept by the predictor, updated on every accepted write to a used index.
  logic [CFG_DW-1:0]         cam_reg [6];
  logic signed [COORD_W-1:0] plane_d;

  point_t point_q [$];
  world_t world_q [$];
  int     err_cnt = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     cyc = 0;
  int     acc_cnt = 0;
  int     hold_cnt = 0;
  logic   hold_rx;
  int     rx_mode = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic wide_t cam_elem(int r, int c);
    logic [CFG_DW-1:0]         rv;
    logic signed [COORD_W-1:0] h;
    wide_t                     v;
    rv = cam_reg[2 * r + c / 2];
    h = (c % 2 == 1) ? rv[31:0] : rv[63:32];
    v = wide_t'(h);
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] round_world(wide_t num, wide_t det);
    umag_t nm, dm, q;
    logic  neg;
    nm = (num < 0) ? umag_t'(-num) : umag_t'(num);
    dm = (det < 0) ? umag_t'(-det) : umag_t'(det);
    neg = (num < 0) != (det < 0);
    q = (2 * nm + dm) / (2 * dm);
    if (neg) begin
      if (q >= umag_t'(1) << 47) return {1'b1, {(OUT_W-1){1'b0}}};
      return -$signed(q[OUT_W-1:0]);
    end
    if (q >= umag_t'(1) << 47) return {1'b0, {(OUT_W-1){1'b1}}};
    return q[OUT_W-1:0];
  endfunction

  function automatic world_t back_project(point_t p);
    wide_t  adj [3][3];
    wide_t  w [3];
    wide_t  det, acc, dd, sc, px, py;
    world_t r;
    int     i1, i2, j1, j2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        i1 = (i + 1) % 3;
        i2 = (i + 2) % 3;
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        adj[i][j] = cam_elem(j1, i1) * cam_elem(j2, i2) - cam_elem(j1, i2) * cam_elem(j2, i1);
      end
    end
    det = cam_elem(0, 0) * adj[0][0] + cam_elem(0, 1) * adj[1][0] + cam_elem(0, 2) * adj[2][0];
    r.wx = '0;
    r.wy = '0;
    r.wz = '0;
    r.sing = 1'b1;
    if (det == 0) return r;
    dd = wide_t'(plane_d);
    sc = wide_t'(1) <<< FRAC;
    px = wide_t'(p.x);
    py = wide_t'(p.y);
    w[0] = px * dd - cam_elem(0, 3) * sc;
    w[1] = py * dd - cam_elem(1, 3) * sc;
    w[2] = sc * dd - cam_elem(2, 3) * sc;
    acc = adj[0][0] * w[0] + adj[0][1] * w[1] + adj[0][2] * w[2];
    r.wx = round_world(acc, det);
    acc = adj[1][0] * w[0] + adj[1][1] * w[1] + adj[1][2] * w[2];
    r.wy = round_world(acc, det);
    acc = adj[2][0] * w[0] + adj[2][1] * w[1] + adj[2][2] * w[2];
    r.wz = round_world(acc, det);
    r.sing = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    err_cnt++;
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
  endtask

  // Register writes are tracked as they are accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_reg[0] <= 64'(1 << FRAC) << 32;
      cam_reg[1] <= '0;
      cam_reg[2] <= 64'(1 << FRAC);
      cam_reg[3] <= '0;
      cam_reg[4] <= '0;
      cam_reg[5] <= 64'(1 << FRAC) << 32;
      plane_d    <= 32'(1 << FRAC);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.addr == CFG_DIST) plane_d <= cfg_ch.data[31:0];
      else if (cfg_ch.addr < CFG_DIST) cam_reg[cfg_ch.addr] <= cfg_ch.data;
    end
  end

  // Point driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t p;
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.x_coord <= '0;
      in_ch.y_coord <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        p.x = in_ch.x_coord;
        p.y = in_ch.y_coord;
        world_q.push_back(back_project(p));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || point_q.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          p = point_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.x_coord <= p.x;
          in_ch.y_coord <= p.y;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // One long hold-off of the receiver once traffic is flowing, so the
  // pipeline fills and stalls in_ch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc      <= 0;
      acc_cnt  <= 0;
      hold_cnt <= 0;
      hold_rx  <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (in_ch.valid && in_ch.ready) acc_cnt <= acc_cnt + 1;
      if (acc_cnt >= HOLD_AT && hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
      hold_rx <= (acc_cnt >= HOLD_AT && hold_cnt < HOLD_LEN);
    end
  end

  // Receiver stall pattern switches among random modes: always ready, mostly ready, mostly stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_mode      <= 0;
    end else begin
      if (cyc % 64 == 0) rx_mode <= $urandom_range(0, 2);
      if (hold_rx) out_ch.ready <= 1'b0;
      else if (rx_mode == 0) out_ch.ready <= 1'b1;
      else if (rx_mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    world_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (world_q.size() == 0) begin
        report_mismatch("unexpected result", out_ch.world_x, '0);
      end else begin
        want = world_q.pop_front();
        if (out_ch.world_x !== want.wx) report_mismatch("world_x", out_ch.world_x, want.wx);
        if (out_ch.world_y !== want.wy) report_mismatch("world_y", out_ch.world_y, want.wy);
        if (out_ch.world_z !== want.wz) report_mismatch("world_z", out_ch.world_z, want.wz);
        if (out_ch.singular !== want.sing) begin
          report_mismatch("singular", OUT_W'(out_ch.singular), OUT_W'(want.sing));
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (point_q.size() != 0 || in_ch.valid || world_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_camera(logic [31:0] m [12], logic [31:0] d);
    wait_idle();
    write_reg(CFG_M00_M01, {m[0], m[1]});
    write_reg(CFG_M02_T0,  {m[2], m[3]});
    write_reg(CFG_M10_M11, {m[4], m[5]});
    write_reg(CFG_M12_T1,  {m[6], m[7]});
    write_reg(CFG_M20_M21, {m[8], m[9]});
    write_reg(CFG_M22_T2,  {m[10], m[11]});
    write_reg(CFG_DIST, CFG_DW'(d));
  endtask

  // Random Q16.16 value with magnitude below 2^bits.
  function automatic logic [31:0] rand_fix(int bits);
    logic [31:0] v;
    v = $urandom();
    if (bits >= 32) return v;
    v = v & ((32'd1 << bits) - 1);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y);
    point_t p;
    p.x = x;
    p.y = y;
    point_q.push_back(p);
  endtask

  task automatic add_random_points(int n, int bits);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) add_point($urandom(), $urandom());
      else add_point(rand_fix(bits), rand_fix(bits));
    end
  endtask

  initial begin
    logic [31:0] m [12];
    logic [31:0] edge_vals [6];
    cfg_ch.valid = 1'b0;
    cfg_ch.addr  = '0;
    cfg_ch.data  = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset camera: coordinate extremes pass straight through.
    edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
                  32'h0000_8000};
    foreach (edge_vals[i]) foreach (edge_vals[j]) add_point(edge_vals[i], edge_vals[j]);
    add_random_points(150, 24);

    // Writes to the unused index must be ignored.
    wait_idle();
    write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_point(32'h0003_0000, 32'hFFFD_0000);
    add_random_points(40, 20);

    // Three well conditioned small cameras, each with a random distance.
    for (int phase = 0; phase < 3; phase++) begin
      foreach (m[k]) m[k] = rand_fix(18);
      m[0] = m[0] + 32'h0004_0000;
      m[5] = m[5] + 32'h0004_0000;
      m[10] = m[10] + 32'h0004_0000;
      set_camera(m, rand_fix(20));
      add_random_points(200, 20);
    end

    // Full range entries and distance extremes drive saturation.
    foreach (m[k]) m[k] = $urandom();
    set_camera(m, 32'h7FFF_FFFF);
    foreach (edge_vals[i]) add_point(edge_vals[i], edge_vals[5 - i]);
    add_random_points(200, 32);
    foreach (m[k]) m[k] = 32'h0;
    m[0] = 32'h7FFF_FFFF;
    m[5] = 32'h8000_0000;
    m[10] = 32'h0000_0001;
    m[3] = 32'h8000_0000;
    m[7] = 32'h7FFF_FFFF;
    set_camera(m, 32'h8000_0000);
    foreach (edge_vals[i]) add_point(edge_vals[i], edge_vals[i]);
    add_random_points(150, 32);

    // Tiny determinant: quotients blow up.
    foreach (m[k]) m[k] = 32'h0;
    m[0] = 32'h0000_0001;
    m[5] = 32'h0000_0001;
    m[10] = 32'h0000_0001;
    m[3] = rand_fix(16);
    set_camera(m, 32'h0001_0000);
    add_random_points(120, 32);

    // All-zero matrix apart from T0, then a rank deficient one: both singular.
    foreach (m[k]) m[k] = 32'h0;
    m[3] = $urandom();
    set_camera(m, $urandom());
    add_random_points(80, 32);
    foreach (m[k]) m[k] = rand_fix(20);
    m[4] = m[0];
    m[5] = m[1];
    m[6] = m[2];
    set_camera(m, $urandom());
    add_random_points(80, 32);

    // Random cameras for the rest of the run, the last one near full range.
    for (int phase = 0; phase < 3; phase++) begin
      foreach (m[k]) m[k] = rand_fix(phase == 2 ? 31 : 22);
      set_camera(m, rand_fix(phase == 2 ? 32 : 22));
      add_random_points(80, 22);
    end

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ pinhole_back_projection_unit.f @@
rtl/pbp_pkg.sv
rtl/pbp_ifs.sv
rtl/pbp_cfg.sv
rtl/pbp_mac.sv
rtl/pbp_div.sv
rtl/pinhole_back_projection_unit.sv
rtl/pbp_chk.sv
test/tb_top.sv
